// ----- sv/spmq_pkg.sv -----
// Shared types and constants for the strict priority multi-queue.
`timescale 1ns / 1ps
package spmq_pkg;

    localparam int PRI_W     = 3;
    localparam int MSG_W     = 16;
    localparam int COUNT_W   = 8;
    localparam int LVL_CFG_W = 4;
    localparam int STATUS_W  = 2;

    typedef logic [MSG_W-1:0] t_msg;
    typedef logic [PRI_W-1:0] t_pri;

    typedef enum logic {
        OP_PUT,
        OP_GET
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_DROPPED,
        ST_FULL
    } t_status;

    localparam logic [LVL_CFG_W-1:0] LEVELS_RESET = 4'd8;
    localparam int REG_LEVELS_IN_USE = 0;

endpackage

// ----- sv/spmq_pri_enc.sv -----
// Priority encoder: lowest-numbered requesting level wins.
`timescale 1ns / 1ps
module spmq_pri_enc #(
    parameter int N = 8,
    parameter int W = 3
) (
    input  logic [N-1:0] i_req,
    output logic         o_found,
    output logic [W-1:0] o_index
);

    always_comb begin
        o_found = 1'b0;
        o_index = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (i_req[i]) begin
                o_found = 1'b1;
                o_index = W'(i);
            end
        end
    end

endmodule

// ----- sv/spmq_store.sv -----
// Handle memory: one write port, one registered read port.
`timescale 1ns / 1ps
module spmq_store #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output spmq_pkg::t_msg    o_rd_data
);
    import spmq_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = MSG_W'(r_rd_data);

endmodule

// ----- sv/strict_priority_multi_queue.sv -----
// Strict priority multi-queue: one FIFO of message handles per priority level.
// Input stream: tuser carries the operation (put or get), tdata carries the
// priority level and the handle. Every accepted item yields exactly one result.
// Output stream: tuser carries the status (ok, empty, dropped, full), tdata the
// dequeued handle, the level it came from and the total number of held handles.
// A get takes the lowest-numbered non-empty level below levels_in_use (0 acts as 1).
// An accepted item is held in the input register and then loaded into the result
// register; the result register and the memory's registered read load together.
// Throughput: one item per cycle while the output is not stalled, set by the level
// counters and pointers and the one-port-per-direction handle memory.
// Reset empties every level and sets levels_in_use to 8; no clearing pass runs.
// When the receiver stalls, the result holds, the input register takes one more
// item, and the input stream then stalls as well.
// levels_in_use lives at APB byte address 0; write it only while idle.
`timescale 1ns / 1ps
module strict_priority_multi_queue #(
    parameter int LEVELS      = 8,
    parameter int LEVEL_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [2:0] priority_req, [18:3] message_id, [23:19] zero
    input  logic        i_s_tuser,   // [0] op
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] message_id_out, [18:16] served_priority,
                                     // [26:19] total_count, [31:27] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);
    import spmq_pkg::*;

    localparam int TOTAL   = LEVELS * LEVEL_DEPTH;
    localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W   = $clog2(LEVEL_DEPTH);
    localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W  = $clog2(TOTAL);
    localparam int TOT_RAW = $clog2(TOTAL + 1);
    localparam int TOT_W   = (TOT_RAW > COUNT_W) ? TOT_RAW : COUNT_W;
    localparam int SW      = (ID_BITS < MSG_W) ? ID_BITS : MSG_W;

    localparam logic [5:0]       LEVELS_L   = 6'(LEVELS);
    localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(LEVEL_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(LEVEL_DEPTH);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(LEVEL_DEPTH);

    // Configuration
    logic [LVL_CFG_W-1:0] r_levels;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == 1'(REG_LEVELS_IN_USE));
    assign prdata = (paddr[2] == 1'(REG_LEVELS_IN_USE)) ? 32'(r_levels) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LEVELS_RESET;
        end else if (cfg_wr) begin
            r_levels <= pwdata[LVL_CFG_W-1:0];
        end
    end

    // Input register
    logic        r_a_valid;
    t_op         r_a_op;
    t_pri        r_a_pri;
    t_msg        r_a_id;
    logic        b_fire;

    assign b_fire     = r_a_valid && (!o_m_tvalid || i_m_tready);
    assign o_s_tready = !r_a_valid || b_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_a_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_a_op  <= t_op'(i_s_tuser);
            r_a_pri <= i_s_tdata[PRI_W-1:0];
            r_a_id  <= i_s_tdata[PRI_W +: MSG_W];
        end
    end

    // Level state
    logic [CNT_W-1:0] r_level_count [LEVELS];
    logic [PTR_W-1:0] r_head [LEVELS];
    logic [PTR_W-1:0] r_tail [LEVELS];
    logic [TOT_W-1:0] r_held_total;

    logic [5:0]        lim;
    logic [5:0]        pri_ext;
    logic [LVL_W-1:0]  pri_idx;
    logic              in_range;
    logic              lvl_full;
    logic              put_ok;
    logic              get_ok;
    logic [LEVELS-1:0] cand;
    logic              found;
    logic [LVL_W-1:0]  sel_lvl;
    logic [5:0]        sel_ext;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [TOT_W-1:0]  n_held_total;
    t_status           n_status;

    always_comb begin
        if (r_levels == '0) begin
            lim = 6'd1;
        end else if (6'(r_levels) > LEVELS_L) begin
            lim = LEVELS_L;
        end else begin
            lim = 6'(r_levels);
        end
        for (int i = 0; i < LEVELS; i++) begin
            cand[i] = (r_level_count[i] != '0) && (6'(i) < lim);
        end
    end

    assign pri_ext  = 6'(r_a_pri);
    assign pri_idx  = pri_ext[LVL_W-1:0];
    assign in_range = pri_ext < lim;
    assign lvl_full = r_level_count[pri_idx] == CNT_FULL;
    assign put_ok   = (r_a_op == OP_PUT) && in_range && !lvl_full;

    spmq_pri_enc #(
        .N (LEVELS),
        .W (LVL_W)
    ) u_pri_enc (
        .i_req   (cand),
        .o_found (found),
        .o_index (sel_lvl)
    );

    assign get_ok  = (r_a_op == OP_GET) && found;
    assign sel_ext = 6'(sel_lvl);
    assign wr_addr = ADDR_W'(pri_idx) * ROW_STEP + ADDR_W'(r_tail[pri_idx]);
    assign rd_addr = ADDR_W'(sel_lvl) * ROW_STEP + ADDR_W'(r_head[sel_lvl]);

    always_comb begin
        n_held_total = r_held_total;
        if (put_ok) begin
            n_held_total = r_held_total + 1'b1;
        end else if (get_ok) begin
            n_held_total = r_held_total - 1'b1;
        end
        if (r_a_op == OP_GET) begin
            n_status = found ? ST_OK : ST_EMPTY;
        end else if (!in_range) begin
            n_status = ST_DROPPED;
        end else if (lvl_full) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_level_count[i] <= '0;
                r_head[i]        <= '0;
                r_tail[i]        <= '0;
            end
            r_held_total <= '0;
        end else if (b_fire) begin
            if (put_ok) begin
                r_level_count[pri_idx] <= r_level_count[pri_idx] + 1'b1;
                r_tail[pri_idx] <= (r_tail[pri_idx] == PTR_LAST) ? '0
                                   : r_tail[pri_idx] + 1'b1;
            end
            if (get_ok) begin
                r_level_count[sel_lvl] <= r_level_count[sel_lvl] - 1'b1;
                r_head[sel_lvl] <= (r_head[sel_lvl] == PTR_LAST) ? '0
                                   : r_head[sel_lvl] + 1'b1;
            end
            r_held_total <= n_held_total;
        end
    end

    // Handle memory
    t_msg rd_data;

    spmq_store #(
        .DEPTH  (TOTAL),
        .ADDR_W (ADDR_W),
        .DATA_W (SW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (b_fire && put_ok),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_a_id[SW-1:0]),
        .i_rd_en   (b_fire && get_ok),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Result register
    logic               r_out_valid;
    t_status            r_out_status;
    logic               r_out_take;
    logic [PRI_W-1:0]   r_out_served;
    logic [COUNT_W-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (b_fire) begin
            r_out_status <= n_status;
            r_out_take   <= get_ok;
            r_out_served <= get_ok ? sel_ext[PRI_W-1:0] : '0;
            r_out_count  <= n_held_total[COUNT_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {5'b0, r_out_count, r_out_served,
                         (r_out_take ? rd_data : t_msg'('0))};

    // Checks
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_total <= TOT_W'(TOTAL))
        else $error("held total exceeds capacity");

    a_put_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire && put_ok |=> r_held_total == $past(r_held_total) + 1'b1)
        else $error("accepted put did not raise the total");

    a_get_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire && get_ok |=> r_held_total == $past(r_held_total) - 1'b1)
        else $error("served get did not lower the total");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != ST_OK) |-> !r_out_take && (r_out_served == '0))
        else $error("failed item carries a handle or level");

endmodule

// ----- sim/spmq_checker.sv -----
// Checker for the strict priority multi-queue: predicts every result item and compares it.
`timescale 1ns / 1ps
module spmq_checker #(
    parameter int LEVELS      = 8,
    parameter int LEVEL_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // [2:0] priority_req, [18:3] message_id, [23:19] zero
    input  logic        i_s_tuser,   // [0] op
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [15:0] message_id_out, [18:16] served_priority,
                                     // [26:19] total_count, [31:27] zero
    input  logic [1:0]  i_m_tuser,   // [1:0] status
    output int          o_err_count,
    output int          o_pending
);
    import spmq_pkg::*;

    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
    localparam logic [2:0] LEVELS_ADDR = 3'(REG_LEVELS_IN_USE * 4);

    typedef struct packed {
        t_status             status;
        t_msg                msg;
        t_pri                served;
        logic [COUNT_W-1:0]  total;
    } t_result;

    t_msg                 fifo_mem [LEVELS][LEVEL_DEPTH];
    logic [PTR_W-1:0]     head_ptr [LEVELS];
    logic [PTR_W-1:0]     tail_ptr [LEVELS];
    logic [FILL_W-1:0]    fill     [LEVELS];
    logic [COUNT_W-1:0]   held;
    logic [LVL_CFG_W-1:0] levels_cfg;
    t_result              expected_q[$];
    int                   err_count = 0;

    assign o_err_count = err_count;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic t_result schedule_item(input t_op op, input t_pri pri, input t_msg id);
        t_result r;
        int      lim;
        r.status = ST_OK;
        r.msg    = '0;
        r.served = '0;
        lim = (levels_cfg == 0) ? 1 : ((levels_cfg > LEVELS) ? LEVELS : int'(levels_cfg));
        if (op == OP_PUT) begin
            if (int'(pri) >= lim) begin
                r.status = ST_DROPPED;
            end else if (fill[pri] >= LEVEL_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                fifo_mem[pri][tail_ptr[pri]] = id;
                tail_ptr[pri] = next_slot(tail_ptr[pri]);
                fill[pri]     = fill[pri] + 1'b1;
                held          = held + 1'b1;
            end
        end else begin
            r.status = ST_EMPTY;
            for (int lv = 0; lv < lim; lv++) begin
                if (r.status == ST_EMPTY && fill[lv] != 0) begin
                    r.status     = ST_OK;
                    r.msg        = fifo_mem[lv][head_ptr[lv]];
                    r.served     = t_pri'(lv);
                    head_ptr[lv] = next_slot(head_ptr[lv]);
                    fill[lv]     = fill[lv] - 1'b1;
                    held         = held - 1'b1;
                end
            end
        end
        r.total = held;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int lv = 0; lv < LEVELS; lv++) begin
                head_ptr[lv] = '0;
                tail_ptr[lv] = '0;
                fill[lv]     = '0;
            end
            held       = '0;
            levels_cfg = LEVELS_RESET;
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status = t_status'(i_m_tuser);
                got.msg    = i_m_tdata[15:0];
                got.served = i_m_tdata[18:16];
                got.total  = i_m_tdata[26:19];
                if (expected_q.size() == 0) begin
                    $error("result item with no expectation: status %0d, handle %0d",
                           i_m_tuser, got.msg);
                    err_count++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("message_id_out", 32'(want.msg), 32'(got.msg));
                    compare_field("served_priority", 32'(want.served), 32'(got.served));
                    compare_field("total_count", 32'(want.total), 32'(got.total));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == LEVELS_ADDR) begin
                levels_cfg = i_pwdata[LVL_CFG_W-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_q.push_back(schedule_item(t_op'(i_s_tuser), i_s_tdata[2:0],
                                                   i_s_tdata[18:3]));
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- sim/tb_strict_priority_multi_queue.sv -----
// Testbench top for the strict priority multi-queue: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb_strict_priority_multi_queue;
    import spmq_pkg::*;

    localparam int SEGMENT_ITEMS = 80;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [2:0] priority_req, [18:3] message_id, [23:19] zero
    logic        s_tuser  = 1'b0; // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [15:0] message_id_out, [18:16] served_priority,
                                  // [26:19] total_count, [31:27] zero
    logic [1:0]  m_tuser;         // [1:0] status
    int          send_idle_pct = 20;
    int          recv_idle_pct = 46;
    int          err_count;
    int          pending;
    int          level_plan[6] = '{8, 2, 15, 1, 5, 8};

    strict_priority_multi_queue i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    spmq_checker i_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input t_op op, input t_pri pri, input t_msg id);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, id, pri};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_levels(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_LEVELS_IN_USE * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_segment(input int n);
        int   left;
        int   burst;
        int   put_pct;
        int   hot;
        t_op  op;
        t_pri pri;
        left = n;
        while (left > 0) begin
            burst   = $urandom_range(40, 8);
            put_pct = ($urandom_range(1) == 1) ? 80 : 25;
            hot     = $urandom_range(7);
            for (int k = 0; k < burst && left > 0; k++) begin
                op  = ($urandom_range(99) < put_pct) ? OP_PUT : OP_GET;
                pri = ($urandom_range(2) == 0) ? t_pri'(hot) : t_pri'($urandom_range(7));
                send_item(op, pri, t_msg'($urandom));
                left--;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_GET, 3'd5, 16'h1234);
        send_item(OP_PUT, 3'd7, 16'h0000);
        send_item(OP_PUT, 3'd0, 16'hFFFF);
        send_item(OP_PUT, 3'd3, 16'hA5A5);
        send_item(OP_PUT, 3'd0, 16'h5A5A);
        repeat (4) send_item(OP_GET, 3'd7, 16'hFFFF);
        send_item(OP_GET, 3'd0, 16'h0000);
        for (int k = 0; k < 17; k++) begin
            send_item(OP_PUT, 3'd2, t_msg'(16'h0100 + k));
        end
        send_item(OP_PUT, 3'd6, 16'h8001);

        drain();
        write_levels(32'd3);
        send_item(OP_PUT, 3'd3, 16'h3333);
        send_item(OP_PUT, 3'd7, 16'h7777);
        send_item(OP_GET, 3'd0, 16'h0000);

        drain();
        write_levels(32'd0);
        send_item(OP_GET, 3'd0, 16'h0000);
        send_item(OP_PUT, 3'd1, 16'h1111);
        send_item(OP_PUT, 3'd0, 16'hC0DE);
        send_item(OP_GET, 3'd0, 16'h0000);

        drain();
        write_levels(32'd15);
        send_item(OP_GET, 3'd0, 16'h0000);
        send_item(OP_PUT, 3'd7, 16'hBEEF);

        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                send_idle_pct = 46;
                recv_idle_pct = 20;
            end else if (seg == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain();
            write_levels(32'(level_plan[seg]));
            random_segment(SEGMENT_ITEMS);
        end

        drain();
        repeat (4) @(posedge clk);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("FAILURE");
        $finish;
    end

endmodule
